[sv/ohci_pkg.sv]
`default_nettype none

package ohci_pkg;

    localparam int MAX_PORTS = 4;
    localparam longint BAR0_SIZE = 4096;

    localparam int PORT_IDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam logic [11:0] PORT_SPAN = 12'(4 * MAX_PORTS);

    // BAR0 sizing answer: every address bit below the decoded size reads as zero
    localparam logic [31:0] BAR0_MASK =
        ~(32'((64'd1 << $clog2(BAR0_SIZE)) - 64'd1));

    typedef enum logic [1:0] {
        KIND_REG_RD = 2'd0,
        KIND_REG_WR = 2'd1,
        KIND_CFG_RD = 2'd2,
        KIND_CFG_WR = 2'd3
    } t_kind;

    localparam logic CFG_IDX_INSTANCE = 1'b0;
    localparam logic CFG_IDX_PORTS    = 1'b1;

    // MMIO register offsets
    localparam logic [11:0] REG_REVISION    = 12'h000;
    localparam logic [11:0] REG_CONTROL     = 12'h004;
    localparam logic [11:0] REG_CMD_STATUS  = 12'h008;
    localparam logic [11:0] REG_INT_ENABLE  = 12'h010;
    localparam logic [11:0] REG_INT_DISABLE = 12'h014;
    localparam logic [11:0] REG_HCCA        = 12'h018;
    localparam logic [11:0] REG_CTRL_HEAD   = 12'h020;
    localparam logic [11:0] REG_BULK_HEAD   = 12'h028;
    localparam logic [11:0] REG_FM_INTERVAL = 12'h034;
    localparam logic [11:0] REG_DESC_A      = 12'h048;
    localparam logic [11:0] REG_PORT_BASE   = 12'h054;

    localparam logic [31:0] DESC_A_FIXED = 32'(1 << 24);
    localparam logic [31:0] HCCA_MASK    = ~32'hFF;

    // PCI config header
    localparam logic [31:0] HDR_DW0_INST0 = 32'h5804_1414;
    localparam logic [31:0] HDR_DW0_INST1 = 32'h5806_1414;
    localparam logic [31:0] HDR_DW1       = 32'h0280_0156;
    localparam logic [31:0] HDR_DW2       = 32'h0C03_100F;
    localparam logic [31:0] HDR_DW3       = 32'h0080_0000;

    localparam logic [7:0] CFG_BAR0_LO   = 8'h10;
    localparam logic [7:0] CFG_BAR0_HI   = 8'h13;
    localparam logic [7:0] CFG_EXP_ROM   = 8'h30;
    localparam logic [2:0] CFG_MAX_BYTES = 3'd4;

    localparam int CFG_LANES = 4;
    localparam int CFG_ROWS  = 64;

    typedef struct packed {
        logic        wr_en;
        logic [11:0] off;
        logic [31:0] wdata;
    } t_mmio_req;

    function automatic logic [7:0] cfg_reset_byte(input logic [5:0] row,
                                                  input logic [1:0] lane,
                                                  input logic       inst);
        logic [31:0] dw;
        case (row)
            6'd0:    dw = inst ? HDR_DW0_INST1 : HDR_DW0_INST0;
            6'd1:    dw = HDR_DW1;
            6'd2:    dw = HDR_DW2;
            6'd3:    dw = HDR_DW3;
            default: dw = 32'd0;
        endcase
        return dw[8*lane +: 8];
    endfunction

endpackage

`default_nettype wire

[sv/ohci_mmio_regs.sv]
`default_nettype none

module ohci_mmio_regs (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ohci_pkg::t_mmio_req i_req,
    input  wire logic [3:0]         i_port_count,
    output logic [31:0]             o_rd_data
);
    import ohci_pkg::*;

    logic [31:0] r_revision;
    logic [31:0] r_control;
    logic [31:0] r_cmd_status;
    logic [31:0] r_int_enable;
    logic [31:0] r_hcca;
    logic [31:0] r_ctrl_head;
    logic [31:0] r_bulk_head;
    logic [31:0] r_fm_interval;
    logic [31:0] r_port [MAX_PORTS];

    logic [11:0]           off_rel;
    logic                  port_hit;
    logic [PORT_IDX_W-1:0] port_idx;
    logic [31:0]           n_cmd_status;

    assign off_rel  = i_req.off - REG_PORT_BASE;
    assign port_hit = (i_req.off >= REG_PORT_BASE) && (off_rel < PORT_SPAN);
    assign port_idx = off_rel[2 +: PORT_IDX_W];

    always_comb begin
        case (i_req.off)
            REG_REVISION:    o_rd_data = r_revision;
            REG_CONTROL:     o_rd_data = r_control;
            REG_CMD_STATUS:  o_rd_data = r_cmd_status;
            REG_INT_ENABLE:  o_rd_data = r_int_enable;
            REG_INT_DISABLE: o_rd_data = r_int_enable;
            REG_HCCA:        o_rd_data = r_hcca;
            REG_CTRL_HEAD:   o_rd_data = r_ctrl_head;
            REG_BULK_HEAD:   o_rd_data = r_bulk_head;
            REG_FM_INTERVAL: o_rd_data = r_fm_interval;
            REG_DESC_A:      o_rd_data = DESC_A_FIXED | {28'd0, i_port_count};
            default:         o_rd_data = port_hit ? r_port[port_idx] : 32'd0;
        endcase
    end

    // HCR self-clears after any register write
    always_comb begin
        n_cmd_status = (i_req.off == REG_CMD_STATUS) ? i_req.wdata : r_cmd_status;
        n_cmd_status[0] = 1'b0;
    end

    // periodic start and hub status are not stored; writes are dropped and reads return zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_revision    <= '0;
            r_control     <= '0;
            r_cmd_status  <= '0;
            r_int_enable  <= '0;
            r_hcca        <= '0;
            r_ctrl_head   <= '0;
            r_bulk_head   <= '0;
            r_fm_interval <= '0;
            for (int p = 0; p < MAX_PORTS; p++) begin
                r_port[p] <= '0;
            end
        end else if (i_req.wr_en) begin
            r_cmd_status <= n_cmd_status;
            case (i_req.off)
                REG_REVISION:    r_revision    <= i_req.wdata;
                REG_CONTROL:     r_control     <= i_req.wdata;
                REG_INT_ENABLE:  r_int_enable  <= r_int_enable | i_req.wdata;
                REG_INT_DISABLE: r_int_enable  <= r_int_enable & ~i_req.wdata;
                REG_HCCA:        r_hcca        <= i_req.wdata & HCCA_MASK;
                REG_CTRL_HEAD:   r_ctrl_head   <= i_req.wdata;
                REG_BULK_HEAD:   r_bulk_head   <= i_req.wdata;
                REG_FM_INTERVAL: r_fm_interval <= i_req.wdata;
                default: begin
                    if (port_hit) begin
                        r_port[port_idx] <= i_req.wdata;
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_hcr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr_en |=> !r_cmd_status[0])
        else $error("command status reset bit survived a write");
    a_hcca_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcca[7:0] == 8'd0)
        else $error("HCCA low bits set");
    a_int_dis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr_en && (i_req.off == REG_INT_DISABLE)
        |=> ((r_int_enable & $past(i_req.wdata)) == 32'd0))
        else $error("interrupt disable left bits set");
`endif

endmodule

`default_nettype wire

[sv/ohci_cfg_space.sv]
`default_nettype none

module ohci_cfg_space (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_acc,
    input  wire logic        i_wr,
    input  wire logic [7:0]  i_addr,
    input  wire logic [2:0]  i_size,
    input  wire logic [31:0] i_wdata,
    input  wire logic        i_inst_wr,
    input  wire logic        i_instance_id,
    output logic [31:0]      o_rd_data
);
    import ohci_pkg::*;

    // byte lane j holds config bytes whose address mod 4 == j
    logic [7:0]          r_mem [CFG_LANES][CFG_ROWS];
    logic [CFG_ROWS-1:0] r_vld [CFG_LANES];

    logic [7:0] r_rd_byte [CFG_LANES];
    logic [5:0] r_rd_row  [CFG_LANES];
    logic       r_rd_vld  [CFG_LANES];
    logic [1:0] r_addr_lo;
    logic [2:0] r_size;

    logic [2:0]  size_c;
    logic [31:0] wval;
    logic [1:0]  lane_i  [CFG_LANES];
    logic [5:0]  lane_row [CFG_LANES];
    logic        lane_we [CFG_LANES];
    logic [7:0]  lane_wd [CFG_LANES];

    assign size_c = (i_size > CFG_MAX_BYTES) ? CFG_MAX_BYTES : i_size;

    always_comb begin
        logic [31:0] v;
        logic [7:0]  a;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < size_c) begin
                v[8*i +: 8] = i_wdata[8*i +: 8];
            end
        end
        if ((i_addr >= CFG_BAR0_LO) && (i_addr <= CFG_BAR0_HI) && (v == '1)) begin
            v = BAR0_MASK;
        end
        if (i_addr == CFG_EXP_ROM) begin
            v = '0;
        end
        wval = v;
        for (int j = 0; j < CFG_LANES; j++) begin
            lane_i[j]   = 2'(j) - i_addr[1:0];
            a           = i_addr + {6'd0, lane_i[j]};
            lane_row[j] = a[7:2];
            lane_we[j]  = i_wr && ({1'b0, lane_i[j]} < size_c);
            lane_wd[j]  = wval[8*lane_i[j] +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < CFG_LANES; j++) begin
            if (i_acc) begin
                r_rd_byte[j] <= r_mem[j][lane_row[j]];
                r_rd_vld[j]  <= r_vld[j][lane_row[j]];
                r_rd_row[j]  <= lane_row[j];
            end
            if (lane_we[j]) begin
                r_mem[j][lane_row[j]] <= lane_wd[j];
            end
        end
        if (i_acc) begin
            r_addr_lo <= i_addr[1:0];
            r_size    <= size_c;
        end
    end

    // entries never written, and dword 0 after an instance write, read as their header or zero reset value
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < CFG_LANES; j++) begin
            if (!i_rst_n) begin
                r_vld[j] <= '0;
            end else begin
                if (lane_we[j]) begin
                    r_vld[j][lane_row[j]] <= 1'b1;
                end
                if (i_inst_wr) begin
                    r_vld[j][0] <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        logic [1:0] ln;
        o_rd_data = '0;
        for (int i = 0; i < 4; i++) begin
            ln = r_addr_lo + 2'(i);
            if (3'(i) < r_size) begin
                o_rd_data[8*i +: 8] = r_rd_vld[ln] ? r_rd_byte[ln]
                                    : cfg_reset_byte(r_rd_row[ln], ln, i_instance_id);
            end
        end
    end

`ifndef SYNTHESIS
    a_inst_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_inst_wr |=> !r_vld[0][0] && !r_vld[1][0] && !r_vld[2][0] && !r_vld[3][0])
        else $error("dword 0 not reloaded after instance change");
    a_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_we[0] && !i_inst_wr |=> r_vld[0][$past(lane_row[0])])
        else $error("written config byte not marked valid");
    a_no_wr_size0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (size_c == 3'd0) |-> !lane_we[0] && !lane_we[1] && !lane_we[2] && !lane_we[3])
        else $error("zero-size config access wrote a byte");
`endif

endmodule

`default_nettype wire

[sv/usb_ohci_register_file.sv]
// An input transfer reaches the result transfer through the input stage and then the result register.
// Throughput: one access per cycle; the input stalls only while the result register
// is full and stalled. Config space reads/writes hit four byte-lane RAMs at accept.
// Reset (synchronous, active low) clears all MMIO registers and pipeline valids, sets
// port_count to 4 and instance_id to 0, and marks every config byte as its reset value.
`default_nettype none

module usb_ohci_register_file (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [11:0] i_offset,
    input  wire logic [2:0]  i_size_bytes,
    input  wire logic [31:0] i_write_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_read_data
);
    import ohci_pkg::*;

    logic        r_instance_id;
    logic [3:0]  r_port_count;

    logic        r_s1_vld;
    t_kind       r_s1_kind;
    logic [11:0] r_s1_off;
    logic [31:0] r_s1_data;

    logic        r_out_vld;
    logic [31:0] r_out_data;

    logic        out_free;
    logic        s1_adv;
    logic        acc;
    logic        inst_wr;
    t_kind       in_kind;
    t_mmio_req   mmio_req;
    logic [31:0] mmio_rd;
    logic [31:0] cfg_rd;
    logic [31:0] n_out_data;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign acc        = i_in_valid && !o_in_stall;
    assign in_kind    = t_kind'(i_kind);
    assign inst_wr    = i_cfg_we && (i_cfg_idx == CFG_IDX_INSTANCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_instance_id <= 1'b0;
            r_port_count  <= 4'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_INSTANCE: r_instance_id <= i_cfg_wdata[0];
                CFG_IDX_PORTS:    r_port_count  <= i_cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= acc || (r_s1_vld && !s1_adv);
            r_out_vld <= s1_adv || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_kind <= in_kind;
            r_s1_off  <= i_offset;
            r_s1_data <= i_write_data;
        end
        if (s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign mmio_req.wr_en = s1_adv && (r_s1_kind == KIND_REG_WR);
    assign mmio_req.off   = r_s1_off;
    assign mmio_req.wdata = r_s1_data;

    ohci_mmio_regs u_mmio (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (mmio_req),
        .i_port_count (r_port_count),
        .o_rd_data    (mmio_rd)
    );

    ohci_cfg_space u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_wr          (acc && (in_kind == KIND_CFG_WR)),
        .i_addr        (i_offset[7:0]),
        .i_size        (i_size_bytes),
        .i_wdata       (i_write_data),
        .i_inst_wr     (inst_wr),
        .i_instance_id (r_instance_id),
        .o_rd_data     (cfg_rd)
    );

    always_comb begin
        case (r_s1_kind)
            KIND_REG_RD: n_out_data = mmio_rd;
            KIND_CFG_RD: n_out_data = cfg_rd;
            default:     n_out_data = 32'd0;
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_read_data = r_out_data;

`ifndef SYNTHESIS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_vld && r_out_vld)
        else $error("input stalled with room in the pipe");
    a_acc_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_s1_vld)
        else $error("accepted transfer lost at input stage");
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_out_valid)
        else $error("advanced item did not reach result register");
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && (r_s1_kind == KIND_REG_WR || r_s1_kind == KIND_CFG_WR)
        |=> o_read_data == 32'd0)
        else $error("write returned nonzero data");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ohci_pkg::*;

    localparam int LIMIT = 200000;
    localparam int PHASE_ITEMS = 250;

    // offsets with no name in the package
    localparam logic [11:0] REG_INT_STATUS  = 12'h00C;
    localparam logic [11:0] REG_PERIOD_ED   = 12'h01C;
    localparam logic [11:0] REG_PERIODIC    = 12'h040;
    localparam logic [11:0] REG_DESC_B      = 12'h04C;
    localparam logic [11:0] REG_HUB_STATUS  = 12'h050;

    class ohci_access_scoreboard;
        logic [31:0] revision, control, cmd_status, int_enable, hcca;
        logic [31:0] ctrl_head, bulk_head, fm_interval, periodic_start, hub_status;
        logic [31:0] port_status [MAX_PORTS];
        logic [7:0]  cfg_bytes [256];
        logic        inst_id;
        logic [3:0]  port_cnt;
        logic [31:0] bar0_size_mask;
        logic [31:0] read_data_q [$];
        int          errors;
        int          checked;

        function new();
            logic [63:0] bit_v;
            bit_v = 64'd2;
            bar0_size_mask = 32'hFFFF_FFFF;
            for (int n = 2; n < 31; n++) begin
                bar0_size_mask &= ~bit_v[31:0];
                bit_v = bit_v << 1;
                if (bit_v >= 64'(BAR0_SIZE))
                    break;
            end
            bar0_size_mask &= ~32'd3;
            errors = 0;
            checked = 0;
            inst_id = 1'b0;
            port_cnt = 4'd4;
            {revision, control, cmd_status, int_enable, hcca} = '0;
            {ctrl_head, bulk_head, fm_interval, periodic_start, hub_status} = '0;
            foreach (port_status[i]) port_status[i] = '0;
            foreach (cfg_bytes[i]) cfg_bytes[i] = '0;
            load_id();
            put_dword(8'h04, HDR_DW1);
            put_dword(8'h08, HDR_DW2);
            put_dword(8'h0C, HDR_DW3);
        endfunction

        function void put_dword(logic [7:0] addr, logic [31:0] v);
            for (int i = 0; i < 4; i++)
                cfg_bytes[8'(addr + i)] = v[8*i +: 8];
        endfunction

        function void load_id();
            put_dword(8'h00, inst_id ? HDR_DW0_INST1 : HDR_DW0_INST0);
        endfunction

        function void set_instance(logic v);
            inst_id = v;
            load_id();
        endfunction

        function void set_port_count(logic [3:0] v);
            port_cnt = v;
        endfunction

        function bit is_port(logic [11:0] off);
            return off >= REG_PORT_BASE && off < REG_PORT_BASE + PORT_SPAN;
        endfunction

        function logic [31:0] reg_value(logic [11:0] off);
            case (off)
                REG_REVISION:    return revision;
                REG_CONTROL:     return control;
                REG_CMD_STATUS:  return cmd_status;
                REG_INT_ENABLE,
                REG_INT_DISABLE: return int_enable;
                REG_HCCA:        return hcca;
                REG_CTRL_HEAD:   return ctrl_head;
                REG_BULK_HEAD:   return bulk_head;
                REG_FM_INTERVAL: return fm_interval;
                REG_DESC_A:      return DESC_A_FIXED | {28'd0, port_cnt};
                default: begin
                    if (is_port(off))
                        return port_status[(off - REG_PORT_BASE) >> 2];
                    return 32'd0;
                end
            endcase
        endfunction

        function void write_reg(logic [11:0] off, logic [31:0] v);
            case (off)
                REG_REVISION:    revision = v;
                REG_CONTROL:     control = v;
                REG_CMD_STATUS:  cmd_status = v;
                REG_INT_ENABLE:  int_enable |= v;
                REG_INT_DISABLE: int_enable &= ~v;
                REG_HCCA:        hcca = v & HCCA_MASK;
                REG_CTRL_HEAD:   ctrl_head = v;
                REG_BULK_HEAD:   bulk_head = v;
                REG_FM_INTERVAL: fm_interval = v;
                REG_PERIODIC:    periodic_start = v;
                REG_HUB_STATUS:  hub_status = v;
                default: begin
                    if (is_port(off))
                        port_status[(off - REG_PORT_BASE) >> 2] = v;
                end
            endcase
            // host controller reset bit is self-clearing
            cmd_status[0] = 1'b0;
        endfunction

        function void note_access(t_kind kind, logic [11:0] off, logic [2:0] size,
                                  logic [31:0] wdata);
            logic [31:0] rd;
            logic [31:0] v;
            logic [2:0]  n;
            logic [7:0]  addr;
            rd = '0;
            v = '0;
            n = (size > CFG_MAX_BYTES) ? CFG_MAX_BYTES : size;
            addr = off[7:0];
            case (kind)
                KIND_REG_RD: rd = reg_value(off);
                KIND_REG_WR: write_reg(off, wdata);
                KIND_CFG_RD: begin
                    for (int i = 0; i < n; i++)
                        rd[8*i +: 8] = cfg_bytes[8'(addr + i)];
                end
                KIND_CFG_WR: begin
                    for (int i = 0; i < n; i++)
                        v[8*i +: 8] = wdata[8*i +: 8];
                    if (addr >= CFG_BAR0_LO && addr < 8'h34) begin
                        if (addr <= CFG_BAR0_HI && v == 32'hFFFF_FFFF)
                            v = bar0_size_mask;
                        if (addr == CFG_EXP_ROM)
                            v = '0;
                    end
                    for (int i = 0; i < n; i++)
                        cfg_bytes[8'(addr + i)] = v[8*i +: 8];
                end
            endcase
            read_data_q.push_back(rd);
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (read_data_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected transfer, read_data=%h", $realtime, got);
                return;
            end
            want = read_data_q.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: read_data mismatch, expected %h got %h",
                             $realtime, want, got);
            end
        endfunction

        function int pending();
            return read_data_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_IDX_INSTANCE;
    logic [3:0]  i_cfg_wdata = 4'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = KIND_REG_RD;
    logic [11:0] i_offset = 12'd0;
    logic [2:0]  i_size_bytes = 3'd4;
    logic [31:0] i_write_data = 32'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_read_data;

    ohci_access_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int n_settings = 0;
    int cycles = 0;

    usb_ohci_register_file i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_offset     (i_offset),
        .i_size_bytes (i_size_bytes),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_read_data);
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_access(input t_kind kind, input logic [11:0] off,
                               input logic [2:0] size, input logic [31:0] wdata);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_offset     <= off;
        i_size_bytes <= size;
        i_write_data <= wdata;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_access(kind, off, size, wdata);
    endtask

    task automatic program_config(input logic inst, input logic [3:0] ports);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_IDX_INSTANCE;
        i_cfg_wdata <= {3'd0, inst};
        @(posedge i_clk);
        sb.set_instance(inst);
        i_cfg_idx   <= CFG_IDX_PORTS;
        i_cfg_wdata <= ports;
        @(posedge i_clk);
        sb.set_port_count(ports);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [11:0] pick_reg_offset();
        case ($urandom_range(15))
            0:  return REG_REVISION;
            1:  return REG_CONTROL;
            2:  return REG_CMD_STATUS;
            3:  return REG_INT_STATUS;
            4:  return REG_INT_ENABLE;
            5:  return REG_INT_DISABLE;
            6:  return REG_HCCA;
            7:  return REG_PERIOD_ED;
            8:  return REG_CTRL_HEAD;
            9:  return REG_BULK_HEAD;
            10: return REG_FM_INTERVAL;
            11: return REG_PERIODIC;
            12: return REG_DESC_A;
            13: return REG_DESC_B;
            14: return REG_HUB_STATUS;
            default: return REG_PORT_BASE + 12'($urandom_range(PORT_SPAN - 1));
        endcase
    endfunction

    task automatic random_access();
        t_kind       kind;
        logic [11:0] off;
        logic [2:0]  size;
        logic [31:0] wdata;
        int          pick;
        kind = t_kind'($urandom_range(3));
        wdata = $urandom();
        case ($urandom_range(7))
            0: wdata = 32'hFFFF_FFFF;
            1: wdata = 32'd0;
            default: ;
        endcase
        size = 3'($urandom_range(1, 4));
        if ($urandom_range(9) == 0)
            size = 3'($urandom_range(7));
        pick = $urandom_range(9);
        if (kind == KIND_REG_RD || kind == KIND_REG_WR) begin
            if (pick < 8)
                off = pick_reg_offset();
            else
                off = 12'($urandom_range(4095));
        end else begin
            off = 12'($urandom_range(4095));
            // most config traffic targets the header and BARs
            if (pick < 6)
                off[7:0] = 8'($urandom_range(8'h3F));
            else if (pick < 7)
                off[7:0] = 8'($urandom_range(8'hFC, 8'hFF));
            if (kind == KIND_CFG_WR && $urandom_range(7) == 0) begin
                off[7:0] = CFG_BAR0_LO + 8'($urandom_range(3));
                size = 3'd4;
                wdata = 32'hFFFF_FFFF;
            end
        end
        send_access(kind, off, size, wdata);
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: header, self-clearing reset bit, set/clear enables, masks, ports, BAR0 sizing, ROM, wrap, odd sizes
        send_access(KIND_CFG_RD, 12'h000, 3'd4, 32'd0);
        send_access(KIND_CFG_RD, 12'hF0C, 3'd4, 32'd0);
        send_access(KIND_REG_WR, REG_CMD_STATUS, 3'd4, 32'hFFFF_FFFF);
        send_access(KIND_REG_RD, REG_CMD_STATUS, 3'd4, 32'd0);
        send_access(KIND_REG_WR, REG_INT_ENABLE, 3'd4, 32'hF0F0_0F0F);
        send_access(KIND_REG_WR, REG_INT_DISABLE, 3'd4, 32'h8000_0001);
        send_access(KIND_REG_RD, REG_INT_DISABLE, 3'd4, 32'd0);
        send_access(KIND_REG_WR, REG_HCCA, 3'd4, 32'hFFFF_FFFF);
        send_access(KIND_REG_RD, REG_HCCA, 3'd4, 32'd0);
        send_access(KIND_REG_RD, REG_DESC_A, 3'd4, 32'd0);
        // unaligned port offsets pick the enclosing port
        send_access(KIND_REG_WR, REG_PORT_BASE + 12'd3, 3'd7, 32'h1234_5678);
        send_access(KIND_REG_WR, REG_PORT_BASE + PORT_SPAN - 12'd1, 3'd0, 32'hCAFE_F00D);
        send_access(KIND_REG_RD, REG_PORT_BASE, 3'd4, 32'd0);
        send_access(KIND_REG_RD, REG_PORT_BASE + PORT_SPAN - 12'd4, 3'd4, 32'd0);
        send_access(KIND_REG_WR, REG_PERIODIC, 3'd4, 32'hFFFF_FFFF);
        send_access(KIND_REG_RD, REG_PERIODIC, 3'd4, 32'd0);
        send_access(KIND_REG_RD, 12'hFFF, 3'd4, 32'd0);
        send_access(KIND_CFG_WR, 12'h010, 3'd4, 32'hFFFF_FFFF);
        send_access(KIND_CFG_RD, 12'h010, 3'd4, 32'd0);
        send_access(KIND_CFG_WR, 12'h030, 3'd4, 32'hDEAD_BEEF);
        send_access(KIND_CFG_RD, 12'h030, 3'd4, 32'd0);
        send_access(KIND_CFG_WR, 12'h0FE, 3'd4, 32'hA5C3_5A3C);
        send_access(KIND_CFG_RD, 12'hAFE, 3'd7, 32'd0);
        send_access(KIND_CFG_WR, 12'h020, 3'd0, 32'hFFFF_FFFF);
        send_access(KIND_CFG_RD, 12'h020, 3'd0, 32'd0);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin program_config(1'b1, 4'd15); idle_pct = 0;  stall_pct = 0;  end
                1: begin program_config(1'b0, 4'd1);  idle_pct = 78; stall_pct = 0;  end
                2: begin program_config(1'b1, 4'd9);  idle_pct = 0;  stall_pct = 78; end
                3: begin program_config(1'b0, 4'd15); idle_pct = 18; stall_pct = 18; end
                default: begin program_config(1'b1, 4'd1); idle_pct = 0; stall_pct = 0; end
            endcase
            repeat (PHASE_ITEMS) random_access();
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        stall_pct = 0;
        repeat (10) @(posedge i_clk);

        $display("checked %0d register and config transfers under %0d cfg settings,",
                 sb.checked, n_settings);
        $display("with BAR0 sizing, ROM, wrap and odd sizes; %0d errors", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
